@@ sv/asched_pkg.sv @@
// ----------------------------------------------------------------------------
// asched_pkg
// shared types, codes and widths for the aligned session scheduler
// ----------------------------------------------------------------------------
package asched_pkg;

    localparam int TIME_W     = 17;   // seconds of day, intervals, timers
    localparam int SLEEP_W    = 16;
    localparam int DVD_W      = 18;   // modulo dividend, holds clock plus sleep
    localparam int STEP_CNT_W = 5;
    localparam int CFG_ADDR_W = 3;
    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 24;

    // operation codes carried in the input item
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_SLEEP = 3'd1;
    localparam logic [2:0] OP_MEAS  = 3'd2;
    localparam logic [2:0] OP_COMM  = 3'd3;
    localparam logic [2:0] OP_LOAD  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_COMM   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RETRY  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DAY    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FORCE  = 3'd4;

    // reset values of the configuration registers
    localparam logic [TIME_W-1:0] SAMPLE_RST = 17'd3600;
    localparam logic [TIME_W-1:0] COMM_RST   = 17'd3600;
    localparam logic [TIME_W-1:0] RETRY_RST  = 17'd600;
    localparam logic [TIME_W-1:0] DAY_RST    = 17'd86400;

    // modulo unit runs one dividend bit per cycle
    localparam logic [STEP_CNT_W-1:0] MOD_LAST_STEP = STEP_CNT_W'(DVD_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_LOAD,
        S_MOD,
        S_WB,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        JOB_CLOCK,
        JOB_MEAS,
        JOB_COMM
    } job_t;

    // zero modulus is treated as one
    function automatic logic [TIME_W-1:0] nonzero17(input logic [TIME_W-1:0] m);
        nonzero17 = (m == '0) ? TIME_W'(1) : m;
    endfunction

endpackage

@@ sv/aligned_session_scheduler.sv @@
// ----------------------------------------------------------------------------
// aligned_session_scheduler
// seconds-of-day clock with measurement and communication session timers
// ----------------------------------------------------------------------------
// Keeps a seconds-of-day clock and two countdown timers. Each input item is
// one event: a half-second tick, a sleep report, a measurement query, a
// communication query or a time load from gps. Every item produces exactly
// one result item carrying session_due, the synced flag and the clock after
// the event. All mod operations (clock wrap, aligning a timer to the next
// interval boundary) go through one restoring remainder unit that handles
// one dividend bit per cycle; a pass through it is a load, 18 steps and a
// write back. An item that needs no modulo (queries that find nothing
// expired or only re-arm with the retry interval, the half-tick that does
// not advance, unused codes) goes from decide through load to done; one
// modulo pass is added for advancing ticks, sleeps, time loads and aligned
// re-arming of one timer, and two for the first synchronizing measurement
// query, which aligns both timers. The sequencer goes back from done to
// idle once the output register can take the result. The input is ready
// only while the sequencer is idle; a finished result waits in the output
// register, so the next item can be accepted before it is taken.
// Configuration writes are taken at any time but are meant to happen only
// while the block is idle.
// ----------------------------------------------------------------------------
module aligned_session_scheduler
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [asched_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [asched_pkg::TIME_W-1:0]         cfg_data,
    // event input
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // sleep_seconds[15:0], gps_valid[16], new_day_time[33:17], zero pad
    input  logic [asched_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // operation[2:0]
    input  logic [asched_pkg::S_TUSER_W-1:0]      s_axis_tuser,
    // result output
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // session_due[0], synced[1], clock_seconds[18:2], zero pad
    output logic [asched_pkg::M_TDATA_W-1:0]      m_axis_tdata
);
    import asched_pkg::*;

    // configuration registers
    logic [TIME_W-1:0]     sample_int_reg;
    logic [TIME_W-1:0]     comm_int_reg;
    logic [TIME_W-1:0]     retry_int_reg;
    logic [TIME_W-1:0]     day_len_reg;
    logic                  force_sync_reg;

    // architectural state
    logic [TIME_W-1:0]     day_seconds_reg,   day_seconds_next;
    logic [TIME_W-1:0]     meas_timer_reg,    meas_timer_next;
    logic [TIME_W-1:0]     comm_timer_reg,    comm_timer_next;
    logic                  sync_flag_reg,     sync_flag_next;
    logic                  half_phase_reg,    half_phase_next;

    // sequencer
    state_t                state_reg,         state_next;
    logic                  job_clk_reg,       job_clk_next;
    logic                  job_meas_reg,      job_meas_next;
    logic                  job_comm_reg,      job_comm_next;
    job_t                  cur_job_reg,       cur_job_next;
    logic                  due_reg,           due_next;

    // captured input item (payload, no reset)
    logic [2:0]            op_reg,            op_next;
    logic [SLEEP_W-1:0]    slept_reg,         slept_next;
    logic                  fix_reg,           fix_next;
    logic [TIME_W-1:0]     load_reg,          load_next;

    // shared remainder unit
    logic [DVD_W-1:0]      clk_dvd_reg,       clk_dvd_next;   // pending clock dividend
    logic [DVD_W-1:0]      dvd_reg,           dvd_next;
    logic [TIME_W-1:0]     div_reg,           div_next;
    logic [TIME_W-1:0]     rem_reg,           rem_next;
    logic [STEP_CNT_W-1:0] step_reg,          step_next;
    logic [DVD_W-1:0]      rem_shift;
    logic [DVD_W-1:0]      rem_sub;

    // output register
    logic                  m_valid_reg,       m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg,        m_data_next;

    logic                  in_accept;
    logic                  out_free;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // one restoring step: bring in next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign rem_sub   = rem_shift - {1'b0, div_reg};

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_int_reg <= SAMPLE_RST;
            comm_int_reg   <= COMM_RST;
            retry_int_reg  <= RETRY_RST;
            day_len_reg    <= DAY_RST;
            force_sync_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SAMPLE: sample_int_reg <= cfg_data;
                CFG_COMM:   comm_int_reg   <= cfg_data;
                CFG_RETRY:  retry_int_reg  <= cfg_data;
                CFG_DAY:    day_len_reg    <= cfg_data;
                CFG_FORCE:  force_sync_reg <= cfg_data[0];
                default:    ;   // unused indexes are ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (job_clk_reg || job_meas_reg || job_comm_reg)
                begin
                    state_next = S_MOD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MOD:
            begin
                if (step_reg == MOD_LAST_STEP)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                state_next = S_LOAD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        day_seconds_next = day_seconds_reg;
        meas_timer_next  = meas_timer_reg;
        comm_timer_next  = comm_timer_reg;
        sync_flag_next   = sync_flag_reg;
        half_phase_next  = half_phase_reg;
        job_clk_next     = job_clk_reg;
        job_meas_next    = job_meas_reg;
        job_comm_next    = job_comm_reg;
        cur_job_next     = cur_job_reg;
        due_next         = due_reg;
        op_next          = op_reg;
        slept_next       = slept_reg;
        fix_next         = fix_reg;
        load_next        = load_reg;
        clk_dvd_next     = clk_dvd_reg;
        dvd_next         = dvd_reg;
        div_next         = div_reg;
        rem_next         = rem_reg;
        step_next        = step_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg;

        // result taken downstream
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next    = s_axis_tuser[2:0];
                    slept_next = s_axis_tdata[15:0];
                    fix_next   = s_axis_tdata[16];
                    load_next  = s_axis_tdata[33:17];
                end
            end
            S_DECIDE:
            begin
                due_next      = 1'b0;
                job_clk_next  = 1'b0;
                job_meas_next = 1'b0;
                job_comm_next = 1'b0;
                unique case (op_reg)
                    OP_TICK:
                    begin
                        half_phase_next = !half_phase_reg;
                        // clock advances on the tick that sets the phase
                        if (!half_phase_reg)
                        begin
                            if (meas_timer_reg != '0)
                            begin
                                meas_timer_next = meas_timer_reg - TIME_W'(1);
                            end
                            if (comm_timer_reg != '0)
                            begin
                                comm_timer_next = comm_timer_reg - TIME_W'(1);
                            end
                            clk_dvd_next = {1'b0, day_seconds_reg} + DVD_W'(1);
                            job_clk_next = 1'b1;
                        end
                    end
                    OP_SLEEP:
                    begin
                        // saturating subtract of slept seconds
                        if (meas_timer_reg < {1'b0, slept_reg})
                        begin
                            meas_timer_next = '0;
                        end
                        else
                        begin
                            meas_timer_next = meas_timer_reg - {1'b0, slept_reg};
                        end
                        if (comm_timer_reg < {1'b0, slept_reg})
                        begin
                            comm_timer_next = '0;
                        end
                        else
                        begin
                            comm_timer_next = comm_timer_reg - {1'b0, slept_reg};
                        end
                        clk_dvd_next = {1'b0, day_seconds_reg} + {2'b00, slept_reg};
                        job_clk_next = 1'b1;
                    end
                    OP_MEAS:
                    begin
                        if (!sync_flag_reg && fix_reg)
                        begin
                            // first fix: align both timers
                            sync_flag_next = 1'b1;
                            job_meas_next  = 1'b1;
                            job_comm_next  = 1'b1;
                        end
                        else if (meas_timer_reg == '0)
                        begin
                            due_next = 1'b1;
                            if (sync_flag_reg)
                            begin
                                job_meas_next = 1'b1;
                            end
                            else
                            begin
                                meas_timer_next = retry_int_reg;
                            end
                        end
                    end
                    OP_COMM:
                    begin
                        if (force_sync_reg)
                        begin
                            sync_flag_next = 1'b1;
                        end
                        if ((sync_flag_reg || force_sync_reg) && comm_timer_reg == '0)
                        begin
                            due_next      = 1'b1;
                            job_comm_next = 1'b1;
                        end
                    end
                    OP_LOAD:
                    begin
                        clk_dvd_next = {1'b0, load_reg};
                        job_clk_next = 1'b1;
                    end
                    default:
                    begin
                        // unused codes change nothing
                    end
                endcase
            end
            S_LOAD:
            begin
                rem_next  = '0;
                step_next = '0;
                priority if (job_clk_reg)
                begin
                    cur_job_next = JOB_CLOCK;
                    dvd_next     = clk_dvd_reg;
                    div_next     = nonzero17(day_len_reg);
                end
                else if (job_meas_reg)
                begin
                    cur_job_next = JOB_MEAS;
                    dvd_next     = {1'b0, day_seconds_reg};
                    div_next     = nonzero17(sample_int_reg);
                end
                else if (job_comm_reg)
                begin
                    cur_job_next = JOB_COMM;
                    dvd_next     = {1'b0, day_seconds_reg};
                    div_next     = nonzero17(comm_int_reg);
                end
                else
                begin
                    cur_job_next = cur_job_reg;
                end
            end
            S_MOD:
            begin
                if (rem_shift >= {1'b0, div_reg})
                begin
                    rem_next = rem_sub[TIME_W-1:0];
                end
                else
                begin
                    rem_next = rem_shift[TIME_W-1:0];
                end
                dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
                step_next = step_reg + STEP_CNT_W'(1);
            end
            S_WB:
            begin
                unique case (cur_job_reg)
                    JOB_CLOCK:
                    begin
                        day_seconds_next = rem_reg;
                        job_clk_next     = 1'b0;
                    end
                    JOB_MEAS:
                    begin
                        // next boundary lies 1..interval seconds ahead
                        meas_timer_next = div_reg - rem_reg;
                        job_meas_next   = 1'b0;
                    end
                    JOB_COMM:
                    begin
                        comm_timer_next = div_reg - rem_reg;
                        job_comm_next   = 1'b0;
                    end
                    default:
                    begin
                        job_clk_next  = 1'b0;
                        job_meas_next = 1'b0;
                        job_comm_next = 1'b0;
                    end
                endcase
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'b0, day_seconds_reg, sync_flag_reg, due_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            day_seconds_reg <= '0;
            meas_timer_reg  <= '0;
            comm_timer_reg  <= '0;
            sync_flag_reg   <= 1'b0;
            half_phase_reg  <= 1'b0;
            job_clk_reg     <= 1'b0;
            job_meas_reg    <= 1'b0;
            job_comm_reg    <= 1'b0;
            cur_job_reg     <= JOB_CLOCK;
            due_reg         <= 1'b0;
            step_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            day_seconds_reg <= day_seconds_next;
            meas_timer_reg  <= meas_timer_next;
            comm_timer_reg  <= comm_timer_next;
            sync_flag_reg   <= sync_flag_next;
            half_phase_reg  <= half_phase_next;
            job_clk_reg     <= job_clk_next;
            job_meas_reg    <= job_meas_next;
            job_comm_reg    <= job_comm_next;
            cur_job_reg     <= cur_job_next;
            due_reg         <= due_next;
            step_reg        <= step_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        slept_reg   <= slept_next;
        fix_reg     <= fix_next;
        load_reg    <= load_next;
        clk_dvd_reg <= clk_dvd_next;
        dvd_reg     <= dvd_next;
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        m_data_reg  <= m_data_next;
    end

`ifndef NO_ASSERTIONS
    // partial remainder stays below the divisor throughout the iteration
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |-> (rem_reg < div_reg))
        else $error("remainder not below divisor");

    // a write back of the clock leaves it below the modulus used
    a_clock_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB && cur_job_reg == JOB_CLOCK) |=>
            (day_seconds_reg < $past(div_reg)))
        else $error("clock not wrapped");

    // an aligned measurement timer is never armed with zero
    a_aligned_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB && cur_job_reg == JOB_MEAS) |=> (meas_timer_reg != '0))
        else $error("aligned measurement timer is zero");

    // no pending modulo job once the sequencer is back to idle
    a_jobs_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !(job_clk_reg || job_meas_reg || job_comm_reg))
        else $error("modulo job left pending");

    // a new result only comes out of the done state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result presented outside done state");
`endif

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the aligned session scheduler
// ----------------------------------------------------------------------------
// A short table of directed events runs first. It covers the field extremes,
// every operation, clock wrap, zero moduli, zero retry and the first sync.
// Random events follow, over several register settings and pacing modes.
// Each accepted item is run through a local copy of the scheduler state; its
// report, or the one typed into its row, is queued and compared with the next result.
// ----------------------------------------------------------------------------
module tb_top;

    import asched_pkg::*;

    // operation codes the block ignores
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    // one event as carried by the input item
    typedef struct packed {
        logic [2:0]        op;
        logic [SLEEP_W-1:0] sleep_s;
        logic              gps;
        logic [TIME_W-1:0] load_s;
    } event_t;

    // one report as carried by the result item
    typedef struct packed {
        logic              due;
        logic              synced;
        logic [TIME_W-1:0] clock_s;
    } report_t;

    typedef enum logic { ROW_EVENT, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t                kind;
        event_t                   ev;
        logic [CFG_ADDR_W-1:0]    idx;
        int unsigned              val;
        bit                       typed;     // report typed into the row
        report_t                  rep;
    } plan_row_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [TIME_W-1:0]     cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    // local copy of the registers
    int unsigned sample_per, comm_per, retry_per, day_len;
    bit          force_sync;

    // local copy of the scheduler state
    int unsigned day_sec, meas_left, comm_left;
    bit          sync_seen, half_phase;

    report_t     reports_in_flight[$];
    plan_row_t   plan[$];
    int unsigned bad_reports   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    aligned_session_scheduler i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // hard limit, several times the slowest legal run
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // scheduler arithmetic
    // ------------------------------------------------------------------

    // zero modulus behaves as one
    function automatic int unsigned at_least_one(input int unsigned m);
        return (m == 0) ? 1 : m;
    endfunction

    // seconds from the clock to the next multiple of the period, 1..period
    function automatic int unsigned to_boundary(input int unsigned period);
        int unsigned m;
        m = at_least_one(period);
        return m - (day_sec % m);
    endfunction

    // advance the local state by one event, return the report it causes
    function automatic report_t apply_event(input event_t e);
        report_t r;
        r.due = 1'b0;
        case (e.op)
            OP_TICK:
            begin
                half_phase = ~half_phase;
                // the clock and timers move on every second half-tick
                if (half_phase)
                begin
                    day_sec = (day_sec + 1) % at_least_one(day_len);
                    if (meas_left != 0) meas_left--;
                    if (comm_left != 0) comm_left--;
                end
            end
            OP_SLEEP:
            begin
                meas_left = (meas_left < e.sleep_s) ? 0 : meas_left - e.sleep_s;
                comm_left = (comm_left < e.sleep_s) ? 0 : comm_left - e.sleep_s;
                day_sec   = (day_sec + e.sleep_s) % at_least_one(day_len);
            end
            OP_MEAS:
            begin
                if (!sync_seen && e.gps)
                begin
                    // first fix: align both timers to the clock
                    sync_seen = 1'b1;
                    meas_left = to_boundary(sample_per);
                    comm_left = to_boundary(comm_per);
                end
                else if (meas_left == 0)
                begin
                    meas_left = sync_seen ? to_boundary(sample_per) : retry_per;
                    r.due     = 1'b1;
                end
            end
            OP_COMM:
            begin
                if (force_sync) sync_seen = 1'b1;
                if (sync_seen && comm_left == 0)
                begin
                    comm_left = to_boundary(comm_per);
                    r.due     = 1'b1;
                end
            end
            OP_LOAD:
            begin
                day_sec = e.load_s % at_least_one(day_len);
            end
            default: ;
        endcase
        r.synced  = sync_seen;
        r.clock_s = day_sec[TIME_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // table rows
    // ------------------------------------------------------------------

    function automatic plan_row_t ev_row(input logic [2:0] op, input int unsigned sl,
                                         input bit g, input int unsigned ld);
        plan_row_t p;
        p.kind       = ROW_EVENT;
        p.ev.op      = op;
        p.ev.sleep_s = sl[SLEEP_W-1:0];
        p.ev.gps     = g;
        p.ev.load_s  = ld[TIME_W-1:0];
        p.idx        = CFG_SAMPLE;
        p.val        = 0;
        p.typed      = 1'b0;
        p.rep        = '0;
        return p;
    endfunction

    // event row with the report written out by hand
    function automatic plan_row_t seen_row(input logic [2:0] op, input int unsigned sl,
                                           input bit g, input int unsigned ld,
                                           input bit due, input bit syn,
                                           input int unsigned clk_s);
        plan_row_t p;
        p           = ev_row(op, sl, g, ld);
        p.typed     = 1'b1;
        p.rep.due   = due;
        p.rep.synced = syn;
        p.rep.clock_s = clk_s[TIME_W-1:0];
        return p;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_ADDR_W-1:0] idx,
                                          input int unsigned val);
        plan_row_t p;
        p       = ev_row(OP_TICK, 0, 1'b0, 0);
        p.kind  = ROW_REG;
        p.idx   = idx;
        p.val   = val;
        return p;
    endfunction

    function automatic event_t random_event();
        event_t      e;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30)      e.op = OP_TICK;
        else if (pick < 50) e.op = OP_SLEEP;
        else if (pick < 70) e.op = OP_MEAS;
        else if (pick < 90) e.op = OP_COMM;
        else if (pick < 97) e.op = OP_LOAD;
        else                e.op = OP_SPARE_A + 3'($urandom_range(2));
        // mostly short sleeps so that the clock walks, some long ones to expire timers
        pick = $urandom_range(9);
        if (pick < 5)      e.sleep_s = SLEEP_W'($urandom_range(15));
        else if (pick < 8) e.sleep_s = SLEEP_W'($urandom_range(4000));
        else               e.sleep_s = SLEEP_W'($urandom_range(16'hffff));
        e.gps = 1'($urandom_range(1));
        if ($urandom_range(4) == 0) e.load_s = TIME_W'($urandom_range(17'h1ffff));
        else                        e.load_s = TIME_W'($urandom_range(86399));
        return e;
    endfunction

    // ------------------------------------------------------------------
    // driving, called and returning at a falling edge
    // ------------------------------------------------------------------

    task automatic offer_event(input event_t e, input bit typed, input report_t typed_rep);
        report_t r;
        // random gaps before the item
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, e.load_s, e.gps, e.sleep_s};
        s_axis_tuser  <= e.op;
        do @(posedge clk); while (!s_axis_tready);
        // accepted at this edge
        r = apply_event(e);
        reports_in_flight.push_back(typed ? typed_rep : r);
        @(negedge clk);
    endtask

    // drop valid and wait until every report has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (reports_in_flight.size() != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val[TIME_W-1:0];
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
        case (idx)
            CFG_SAMPLE: sample_per = val & 32'h1ffff;
            CFG_COMM:   comm_per   = val & 32'h1ffff;
            CFG_RETRY:  retry_per  = val & 32'h1ffff;
            CFG_DAY:    day_len    = val & 32'h1ffff;
            CFG_FORCE:  force_sync = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int unsigned s, input int unsigned c,
                                 input int unsigned r, input int unsigned d,
                                 input int unsigned f);
        wait_drained();
        write_reg(CFG_SAMPLE, s);
        write_reg(CFG_COMM, c);
        write_reg(CFG_RETRY, r);
        write_reg(CFG_DAY, d);
        write_reg(CFG_FORCE, f);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // receiver stalls at the rate of the current pacing mode
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : watch_results
        report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (reports_in_flight.size() == 0)
            begin
                $error("result item with nothing pending, tdata %h", m_axis_tdata);
                bad_reports++;
            end
            else
            begin
                want = reports_in_flight.pop_front();
                if (m_axis_tdata[0] !== want.due)
                begin
                    $error("session_due: expected %0d, got %0d", want.due, m_axis_tdata[0]);
                    bad_reports++;
                end
                if (m_axis_tdata[1] !== want.synced)
                begin
                    $error("synced: expected %0d, got %0d", want.synced, m_axis_tdata[1]);
                    bad_reports++;
                end
                if (m_axis_tdata[TIME_W+1:2] !== want.clock_s)
                begin
                    $error("clock_seconds: expected %0d, got %0d",
                           want.clock_s, m_axis_tdata[TIME_W+1:2]);
                    bad_reports++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        sample_per = SAMPLE_RST;
        comm_per   = COMM_RST;
        retry_per  = RETRY_RST;
        day_len    = DAY_RST;
        force_sync = 1'b0;
        day_sec    = 0;
        meas_left  = 0;
        comm_left  = 0;
        sync_seen  = 1'b0;
        half_phase = 1'b0;

        // directed table, reset settings first
        plan.push_back(seen_row(OP_TICK, 0, 0, 0, 0, 0, 1));         // first tick advances
        plan.push_back(seen_row(OP_TICK, 0, 0, 0, 0, 0, 1));         // second one does not
        plan.push_back(seen_row(OP_COMM, 0, 0, 0, 0, 0, 1));         // comm ignored unsynced
        plan.push_back(seen_row(OP_MEAS, 0, 0, 0, 1, 0, 1));         // expired, retry armed
        plan.push_back(seen_row(OP_MEAS, 0, 0, 0, 0, 0, 1));
        plan.push_back(seen_row(OP_SLEEP, 16'hffff, 0, 0, 0, 0, 65536));
        plan.push_back(reg_row(CFG_RETRY, 0));
        plan.push_back(seen_row(OP_MEAS, 0, 0, 0, 1, 0, 65536));     // zero retry stays due
        plan.push_back(seen_row(OP_MEAS, 0, 0, 0, 1, 0, 65536));
        plan.push_back(reg_row(CFG_RETRY, 600));
        plan.push_back(seen_row(OP_LOAD, 0, 0, 86399, 0, 0, 86399));
        plan.push_back(seen_row(OP_TICK, 0, 0, 0, 0, 0, 0));         // wraps at day length
        plan.push_back(seen_row(OP_LOAD, 0, 0, 17'h1ffff, 0, 0, 44671));
        plan.push_back(seen_row(OP_SLEEP, 0, 0, 0, 0, 0, 44671));
        plan.push_back(seen_row(OP_MEAS, 0, 1, 0, 0, 1, 44671));     // first fix, sync
        plan.push_back(seen_row(OP_COMM, 0, 0, 0, 0, 1, 44671));
        plan.push_back(seen_row(OP_SLEEP, 41729, 0, 0, 0, 1, 0));    // lands on day length
        plan.push_back(seen_row(OP_COMM, 0, 0, 0, 1, 1, 0));
        plan.push_back(seen_row(OP_MEAS, 0, 0, 0, 1, 1, 0));
        plan.push_back(seen_row(OP_SPARE_A, 0, 0, 0, 0, 1, 0));
        plan.push_back(seen_row(OP_SPARE_C, 16'hffff, 1, 17'h1ffff, 0, 1, 0));
        // zero moduli and forced sync
        plan.push_back(reg_row(CFG_DAY, 0));
        plan.push_back(reg_row(CFG_SAMPLE, 0));
        plan.push_back(reg_row(CFG_COMM, 0));
        plan.push_back(reg_row(CFG_FORCE, 1));
        plan.push_back(ev_row(OP_TICK, 0, 0, 0));
        plan.push_back(ev_row(OP_TICK, 0, 0, 0));
        plan.push_back(ev_row(OP_SLEEP, 16'hffff, 0, 0));
        plan.push_back(ev_row(OP_MEAS, 0, 1, 0));
        plan.push_back(ev_row(OP_COMM, 0, 0, 0));
        // largest day length, one-day sample and retry intervals
        plan.push_back(reg_row(CFG_DAY, 17'h1ffff));
        plan.push_back(reg_row(CFG_SAMPLE, 86400));
        plan.push_back(reg_row(CFG_RETRY, 86400));
        plan.push_back(reg_row(CFG_FORCE, 0));
        plan.push_back(ev_row(OP_LOAD, 0, 0, 17'h1ffff));
        plan.push_back(ev_row(OP_SLEEP, 16'hffff, 0, 0));
        plan.push_back(ev_row(OP_MEAS, 0, 0, 0));

        // reset held low at start, released away from the rising edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                wait_drained();
                write_reg(plan[i].idx, plan[i].val);
            end
            else
            begin
                offer_event(plan[i].ev, plan[i].typed, plan[i].rep);
            end
        end

        // random part, one register setting and pacing mode per phase
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: apply_setting(SAMPLE_RST, COMM_RST, RETRY_RST, DAY_RST, 0);
                1: apply_setting(7, 5, 3, 20, 0);
                2: apply_setting(1, 1, 1, 1, 1);
                3: apply_setting(86400, 86400, 86400, 86400, 0);
                4: apply_setting(0, 0, 0, 0, 1);
                5: apply_setting($urandom_range(1, 30), $urandom_range(1, 30),
                                 $urandom_range(30), $urandom_range(1, 100), 0);
                6: apply_setting($urandom_range(17'h1ffff), $urandom_range(17'h1ffff),
                                 $urandom_range(17'h1ffff), $urandom_range(17'h1ffff),
                                 $urandom_range(1));
                default: apply_setting($urandom_range(1, 600), $urandom_range(1, 600),
                                       $urandom_range(1, 600), $urandom_range(600, 86400),
                                       $urandom_range(1));
            endcase
            // pacing: none, sender gaps, receiver stalls, both light
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 72;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 72;
                end
                default:
                begin
                    send_idle_pct  = 16;
                    recv_stall_pct = 16;
                end
            endcase
            repeat (170) offer_event(random_event(), 1'b0, '0);
        end

        // drain, then give the block time to show any stray result
        wait_drained();
        repeat (60) @(posedge clk);
        if (bad_reports == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
sv/asched_pkg.sv
sv/aligned_session_scheduler.sv
test/tb_top.sv
